FILE: src/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, constants and byte functions for the block cipher core.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

  localparam int unsigned NUM_ROUNDS = 10;

  // Register indexes of the configuration port
  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW  = 1'b1;

  localparam logic [7:0] GF_POLY = 8'h1B;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEYEXP,
    ST_ROUND,
    ST_OUT
  } aes_state_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_block;   // capture plaintext, apply first round key
    logic       key_start;    // reset key schedule to cipher key
    logic       key_step;     // advance key schedule by one round
    logic       round_step;   // run one cipher round
    logic       last_round;   // skip column mixing
    logic [3:0] rnd;          // round number being produced
  } aes_cmd_t;

  typedef logic [7:0] sbox_arr_t [256];

  localparam sbox_arr_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Round constant for round rnd (1..10)
  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] r;
    begin
      case (rnd)
        4'd1:    r = 8'h01;
        4'd2:    r = 8'h02;
        4'd3:    r = 8'h04;
        4'd4:    r = 8'h08;
        4'd5:    r = 8'h10;
        4'd6:    r = 8'h20;
        4'd7:    r = 8'h40;
        4'd8:    r = 8'h80;
        4'd9:    r = 8'h1B;
        4'd10:   r = 8'h36;
        default: r = 8'h00;
      endcase
      return r;
    end
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? GF_POLY : 8'h00);
  endfunction

endpackage

`default_nettype wire

FILE: src/aes_ctrl.sv
// ----------------------------------------------------------------------------
// AES-128 controller
// Sequences key schedule setup, ten rounds and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic            out_fire,
  output logic                 in_ready,
  output logic                 out_valid,
  output aes_pkg::aes_cmd_t    cmd
);

  aes_pkg::aes_state_t state_r, state_nxt;
  logic [3:0]          rnd_r, rnd_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aes_pkg::ST_IDLE;
      rnd_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt      = state_r;
    rnd_nxt        = rnd_r;
    in_ready       = 1'b0;
    out_valid      = 1'b0;
    cmd            = '0;
    cmd.rnd        = rnd_r;
    cmd.last_round = (rnd_r == 4'(aes_pkg::NUM_ROUNDS));
    case (state_r)
      aes_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load_block = 1'b1;
          cmd.key_start  = 1'b1;
          rnd_nxt        = 4'd1;
          state_nxt      = aes_pkg::ST_ROUND;
        end
      end
      aes_pkg::ST_ROUND: begin
        cmd.round_step = 1'b1;
        cmd.key_step   = 1'b1;
        rnd_nxt        = rnd_r + 4'd1;
        if (cmd.last_round) state_nxt = aes_pkg::ST_OUT;
      end
      aes_pkg::ST_OUT: begin
        out_valid = 1'b1;
        in_ready  = out_fire;
        if (out_fire) begin
          state_nxt = aes_pkg::ST_IDLE;
          if (in_fire) begin
            cmd.load_block = 1'b1;
            cmd.key_start  = 1'b1;
            rnd_nxt        = 4'd1;
            state_nxt      = aes_pkg::ST_ROUND;
          end
        end
      end
      default: state_nxt = aes_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/aes_datapath.sv
// ----------------------------------------------------------------------------
// AES-128 datapath
// Key registers, on-the-fly key schedule and one shared round unit.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_sel,
  input  wire logic [63:0]       cfg_data,
  input  wire logic [127:0]      plain,
  input  wire aes_pkg::aes_cmd_t cmd,
  output logic [127:0]           cipher
);

  logic [127:0] key_r;
  logic [127:0] rkey_r, rkey_nxt;
  logic [127:0] state_r;
  logic [127:0] sb, mc, rnd_out;
  logic [31:0]  w3, tw;

  // Key register writes; both halves clear at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      if (cfg_sel == aes_pkg::REG_KEY_HIGH) key_r[127:64] <= cfg_data;
      else                                  key_r[63:0]   <= cfg_data;
    end
  end

  // Next round key from the current one
  always_comb begin
    w3 = rkey_r[31:0];
    tw = {aes_pkg::SBOX[w3[23:16]] ^ aes_pkg::rcon(cmd.rnd), aes_pkg::SBOX[w3[15:8]],
          aes_pkg::SBOX[w3[7:0]], aes_pkg::SBOX[w3[31:24]]};
    rkey_nxt[127:96] = rkey_r[127:96] ^ tw;
    rkey_nxt[95:64]  = rkey_r[95:64] ^ rkey_nxt[127:96];
    rkey_nxt[63:32]  = rkey_r[63:32] ^ rkey_nxt[95:64];
    rkey_nxt[31:0]   = rkey_r[31:0] ^ rkey_nxt[63:32];
  end

  // Sub bytes with shift rows, then mix columns (skipped in the last round) and round key; byte n sits at bits 127-8n
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[127 - 8*(4*c + r) -: 8] = aes_pkg::SBOX[state_r[127 - 8*(4*((c + r) % 4) + r) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, all;
      a0  = sb[127 - 32*c -: 8];
      a1  = sb[119 - 32*c -: 8];
      a2  = sb[111 - 32*c -: 8];
      a3  = sb[103 - 32*c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      mc[127 - 32*c -: 8] = a0 ^ all ^ aes_pkg::xtime(a0 ^ a1);
      mc[119 - 32*c -: 8] = a1 ^ all ^ aes_pkg::xtime(a1 ^ a2);
      mc[111 - 32*c -: 8] = a2 ^ all ^ aes_pkg::xtime(a2 ^ a3);
      mc[103 - 32*c -: 8] = a3 ^ all ^ aes_pkg::xtime(a3 ^ a0);
    end
    rnd_out = (cmd.last_round ? sb : mc) ^ rkey_nxt;
  end

  // Round key and cipher state registers
  always_ff @(posedge clk) begin
    if (cmd.key_start)     rkey_r <= key_r;
    else if (cmd.key_step) rkey_r <= rkey_nxt;
    if (cmd.load_block)      state_r <= plain ^ key_r;
    else if (cmd.round_step) state_r <= rnd_out;
  end

  assign cipher = state_r;

endmodule

`default_nettype wire

FILE: src/aes128_block_encrypt_core.sv
// ----------------------------------------------------------------------------
// AES-128 block encryption core
// Encrypts one 128-bit block per transfer under a configured 128-bit key.
// ----------------------------------------------------------------------------
// Usage:
//   Write the key over the cfg channel (index 0 key bytes 0..7, index 1
//   bytes 8..15) while the core is idle. Writes are always accepted.
//   Each in transfer carries one plaintext block; one out transfer returns
//   its ciphertext. The first round key is added as the block is taken, then
//   one round per cycle runs through a single shared round unit whose key
//   schedule advances alongside it.
//   Only one block is in flight: the next block is taken no earlier than
//   the cycle its predecessor's result transfers, and can be taken then.
//   When the receiver stalls, the ciphertext holds on out_tdata and in_tready
//   stays low. Reset clears the controller to idle and both key halves to
//   zero; write the key before the first block.
//   tdata fields, lowest bits first: high half then low half.
// ----------------------------------------------------------------------------
`default_nettype none

module aes128_block_encrypt_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [63:0]  cfg_data,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // [63:0] plain_high, [127:64] plain_low
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata   // [63:0] cipher_high, [127:64] cipher_low
);

  aes_pkg::aes_cmd_t cmd;
  logic [127:0]      cipher;

  assign cfg_ready = 1'b1;

  aes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_tvalid & in_tready),
    .out_fire  (out_tvalid & out_tready),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .cmd       (cmd)
  );

  aes_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid),
    .cfg_sel  (cfg_index),
    .cfg_data (cfg_data),
    .plain    ({in_tdata[63:0], in_tdata[127:64]}),
    .cmd      (cmd),
    .cipher   (cipher)
  );

  // Swap halves to tdata order
  assign out_tdata = {cipher[63:0], cipher[127:64]};

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 block encryption core testbench
// Writes cipher keys over the configuration channel, streams plaintext blocks
// with bursty input and a stalling receiver, and checks every ciphertext
// against a behavioural AES-128 cipher kept in the testbench.
// ----------------------------------------------------------------------------
module tb;

  logic         clk;
  logic         rst_n;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [0:0]   cfg_index;
  logic [63:0]  cfg_data;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;   // [63:0] plain_high, [127:64] plain_low
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // [63:0] cipher_high, [127:64] cipher_low

  aes128_block_encrypt_core DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Cipher state held by the testbench: key halves and expanded schedule
  logic [63:0]  key_hi_q, key_lo_q;
  logic [31:0]  sched_words [44];
  logic [127:0] cipher_queue [$];   // {cipher_high, cipher_low}
  int           error_count;
  int           blocks_sent;
  int           blocks_checked;
  int           keys_loaded;
  int           burst_left;
  int           stall_mode;

  // Clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic logic [7:0] gf_double(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
  endfunction

  // Rebuild the 44-word key schedule from the two key halves
  function automatic void expand_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    sched_words[0] = key_hi_q[63:32];
    sched_words[1] = key_hi_q[31:0];
    sched_words[2] = key_lo_q[63:32];
    sched_words[3] = key_lo_q[31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched_words[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {aes_pkg::SBOX[t[31:24]], aes_pkg::SBOX[t[23:16]],
             aes_pkg::SBOX[t[15:8]], aes_pkg::SBOX[t[7:0]]};
        t[31:24] = t[31:24] ^ rc;
        rc = gf_double(rc);
      end
      sched_words[i] = sched_words[i-4] ^ t;
    end
  endfunction

  // Full AES-128 encryption; byte 0 of the block sits in bits 127..120
  function automatic logic [127:0] aes_encrypt(input logic [127:0] blk);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    for (int rnd = 0; rnd <= 10; rnd++) begin
      if (rnd > 0) begin
        // sub bytes and shift rows
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++)
            t[4*c+r] = aes_pkg::SBOX[s[4*((c+r)%4)+r]];
        s = t;
        // mix columns except in the last round
        if (rnd < 10) begin
          for (int c = 0; c < 4; c++) begin
            a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
            all = a0 ^ a1 ^ a2 ^ a3;
            s[4*c]   = a0 ^ all ^ gf_double(a0 ^ a1);
            s[4*c+1] = a1 ^ all ^ gf_double(a1 ^ a2);
            s[4*c+2] = a2 ^ all ^ gf_double(a2 ^ a3);
            s[4*c+3] = a3 ^ all ^ gf_double(a3 ^ a0);
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          s[4*c+r] = s[4*c+r] ^ sched_words[rnd*4+c][31-8*r -: 8];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = s[i];
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Receiver: change stall pattern every so often, including stall-free runs
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Check each result transfer against the oldest expected ciphertext
  always @(posedge clk) begin
    logic [127:0] exp_blk;
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_queue.size() == 0) begin
        $error("unexpected result transfer: %h", out_tdata);
        error_count++;
      end else begin
        exp_blk = cipher_queue.pop_front();
        blocks_checked++;
        if (out_tdata[63:0] !== exp_blk[127:64]) begin
          $error("cipher_high expected %h actual %h", exp_blk[127:64], out_tdata[63:0]);
          error_count++;
        end
        if (out_tdata[127:64] !== exp_blk[63:0]) begin
          $error("cipher_low expected %h actual %h", exp_blk[63:0], out_tdata[127:64]);
          error_count++;
        end
      end
    end
  end

  // Hold until every expected ciphertext has come back, then let the core settle
  task automatic wait_drained();
    while (cipher_queue.size() != 0) @(negedge clk);
    repeat (15) @(negedge clk);
  endtask

  // One register write transfer; the testbench schedule is re-expanded from the updated halves
  task automatic write_reg(input logic [0:0] idx, input logic [63:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == aes_pkg::REG_KEY_HIGH) key_hi_q = val;
    else key_lo_q = val;
    expand_schedule();
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
    wait_drained();
    write_reg(aes_pkg::REG_KEY_HIGH, hi);
    write_reg(aes_pkg::REG_KEY_LOW, lo);
    keys_loaded++;
  endtask

  // Send one plaintext block; bursts of random length with random gaps
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_tdata  = {lo, hi};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    cipher_queue.push_back(aes_encrypt({hi, lo}));
    blocks_sent++;
    burst_left--;
    @(negedge clk);
    if (burst_left == 0) in_tvalid = 1'b0;
  endtask

  task automatic finish_stream();
    in_tvalid = 1'b0;
  endtask

  // Standard test vector plus field extremes
  task automatic test_known_vectors();
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(64'h0, 64'h0);
    send_block('1, '1);
    send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    finish_stream();
    load_key(64'h0, 64'h0);
    send_block(64'h0, 64'h0);
    send_block('1, '1);
    send_block(64'h8000000000000000, 64'h1);
    finish_stream();
    load_key('1, '1);
    send_block(64'h0, 64'h0);
    send_block('1, '1);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210);
    finish_stream();
    // change one half only: schedule must use the held other half
    wait_drained();
    write_reg(aes_pkg::REG_KEY_LOW, 64'h0);
    send_block(64'h0, '1);
    send_block('1, 64'h0);
    finish_stream();
    wait_drained();
    write_reg(aes_pkg::REG_KEY_HIGH, 64'h2b7e151628aed2a6);
    send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a);
    finish_stream();
  endtask

  // Random plaintexts under a series of keys, extremes among them
  task automatic test_random_blocks();
    logic [63:0] kh, kl, ph, pl;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin kh = '0; kl = '0; end
        1: begin kh = '1; kl = '1; end
        2: begin kh = '0; kl = '1; end
        default: begin kh = rand64(); kl = rand64(); end
      endcase
      load_key(kh, kl);
      for (int n = 0; n < 125; n++) begin
        ph = rand64();
        pl = rand64();
        if ($urandom_range(0, 31) == 0) ph = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 31) == 0) pl = $urandom_range(0, 1) ? '1 : '0;
        send_block(ph, pl);
      end
      finish_stream();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    stall_mode = 0;
    burst_left = 0;
    error_count = 0;
    blocks_sent = 0;
    blocks_checked = 0;
    keys_loaded = 0;
    key_hi_q = '0;
    key_lo_q = '0;
    expand_schedule();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_known_vectors();
    test_random_blocks();

    wait_drained();
    repeat (10) @(posedge clk);
    $display("Encrypted %0d blocks under %0d key loads; %0d ciphertexts checked.",
             blocks_sent, keys_loaded, blocks_checked);
    if (error_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("timeout with %0d results outstanding", cipher_queue.size());
    $display("tb NOT OK");
    $finish;
  end

endmodule
